>>> sv/nec_ir_pkg.sv
// Shared types, register codes, reset values and the pulse length match function.
package nec_ir_pkg;

    typedef struct packed {
        logic        pulse_level;
        logic [15:0] pulse_ticks;
    } in_word_t;

    typedef struct packed {
        logic [15:0] key_code;
        logic        is_repeat;
    } out_word_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HEADER,
        PH_MARK,
        PH_SPACE
    } phase_t;

    typedef enum logic [2:0] {
        CFG_HEADER_MARK,
        CFG_HEADER_SPACE,
        CFG_REPEAT_SPACE,
        CFG_BIT_MARK,
        CFG_ONE_SPACE,
        CFG_ZERO_SPACE,
        CFG_ABS_TOLERANCE,
        CFG_DEVICE_ADDRESS
    } cfg_index_t;

    localparam logic [15:0] HEADER_MARK_RST    = 16'd1699;
    localparam logic [15:0] HEADER_SPACE_RST   = 16'd833;
    localparam logic [15:0] REPEAT_SPACE_RST   = 16'd411;
    localparam logic [15:0] BIT_MARK_RST       = 16'd115;
    localparam logic [15:0] ONE_SPACE_RST      = 16'd306;
    localparam logic [15:0] ZERO_SPACE_RST     = 16'd95;
    localparam logic [15:0] ABS_TOLERANCE_RST  = 16'd100;
    localparam logic [15:0] DEVICE_ADDRESS_RST = 16'hC03F;

    localparam logic [5:0] ADDR_BITS  = 6'd16;
    localparam logic [5:0] FRAME_BITS = 6'd32;

    // The length matches when the deviation is within the tolerance and within a
    // third of the reference. For an integer deviation, d <= ref / 3 is the same
    // as 3 * d <= ref, which avoids any division.
    function automatic logic near_ref(input logic [15:0] ref_ticks,
                                      input logic [15:0] len_ticks,
                                      input logic [15:0] tol_ticks);
        logic [15:0] diff;
        logic [17:0] diff_x3;
        diff    = (len_ticks >= ref_ticks) ? (len_ticks - ref_ticks)
                                           : (ref_ticks - len_ticks);
        diff_x3 = {2'b00, diff} + {1'b0, diff, 1'b0};
        return (diff <= tol_ticks) && (diff_x3 <= {2'b00, ref_ticks});
    endfunction

endpackage

>>> sv/nec_ir_pulse_decoder.sv
// Top level of the NEC infrared pulse decoder with its configuration registers.
//
// Each input word on the s_ channel is one measured pulse: its level (1 for a
// mark) and its length in timer ticks. The decoder walks the header, the 16
// address bits and the 16 command bits, and emits one output word on the m_
// channel for each complete frame whose address equals the device address
// (is_repeat = 0) and for each repeat header (is_repeat = 1, held word).
// Pulses that fit no expectation return the decoder to idle without output.
// A pulse word is registered at acceptance and decoded from the input register
// into the output register, which drives m_valid and m_data.
// One pulse is accepted every cycle; the only limit is the output
// register, which holds a result until m_ready takes it. While the receiver
// stalls, one more pulse is accepted and waits in the input register, and
// s_ready then stays low until the output register frees up.
// The configuration port writes one 16-bit register per cycle with cfg_wr_en;
// write it only while no pulse is being decoded. The synchronous active-low
// reset clears the decoder to idle, empties both registers and loads the
// default timing and address values.
module nec_ir_pulse_decoder (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  nec_ir_pkg::cfg_index_t cfg_index,
    input  logic [15:0]            cfg_data,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  nec_ir_pkg::in_word_t   s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output nec_ir_pkg::out_word_t  m_data
);
    import nec_ir_pkg::*;

    logic [15:0] header_mark_reg;
    logic [15:0] header_space_reg;
    logic [15:0] repeat_space_reg;
    logic [15:0] bit_mark_reg;
    logic [15:0] one_space_reg;
    logic [15:0] zero_space_reg;
    logic [15:0] abs_tolerance_reg;
    logic [15:0] device_address_reg;

    logic        in_valid_reg;
    in_word_t    in_data_reg;
    logic        m_valid_reg;
    out_word_t   m_data_reg;

    phase_t      phase_reg;
    phase_t      phase_next;
    logic [5:0]  bit_count_reg;
    logic [5:0]  bit_count_next;
    logic [15:0] shift_word_reg;
    logic [15:0] shift_word_next;

    logic        out_free;
    logic        advance;
    logic        res_valid;
    out_word_t   res_word;
    logic [15:0] ref_a;
    logic [15:0] ref_b;
    logic        match_a;
    logic        match_b;
    logic        is_mark;
    logic [5:0]  count_inc;
    logic [15:0] shifted;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_mark_reg    <= HEADER_MARK_RST;
            header_space_reg   <= HEADER_SPACE_RST;
            repeat_space_reg   <= REPEAT_SPACE_RST;
            bit_mark_reg       <= BIT_MARK_RST;
            one_space_reg      <= ONE_SPACE_RST;
            zero_space_reg     <= ZERO_SPACE_RST;
            abs_tolerance_reg  <= ABS_TOLERANCE_RST;
            device_address_reg <= DEVICE_ADDRESS_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_HEADER_MARK:    header_mark_reg    <= cfg_data;
                CFG_HEADER_SPACE:   header_space_reg   <= cfg_data;
                CFG_REPEAT_SPACE:   repeat_space_reg   <= cfg_data;
                CFG_BIT_MARK:       bit_mark_reg       <= cfg_data;
                CFG_ONE_SPACE:      one_space_reg      <= cfg_data;
                CFG_ZERO_SPACE:     zero_space_reg     <= cfg_data;
                CFG_ABS_TOLERANCE:  abs_tolerance_reg  <= cfg_data;
                CFG_DEVICE_ADDRESS: device_address_reg <= cfg_data;
            endcase
        end
    end

    assign out_free = !m_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    // Only two references can matter in any phase, so two comparators serve all.
    always_comb begin
        unique case (phase_reg)
            PH_IDLE: begin
                ref_a = header_mark_reg;
                ref_b = header_mark_reg;
            end
            PH_HEADER: begin
                ref_a = repeat_space_reg;
                ref_b = header_space_reg;
            end
            PH_MARK: begin
                ref_a = bit_mark_reg;
                ref_b = bit_mark_reg;
            end
            PH_SPACE: begin
                ref_a = one_space_reg;
                ref_b = zero_space_reg;
            end
        endcase
    end

    assign is_mark   = in_data_reg.pulse_level;
    assign match_a   = near_ref(ref_a, in_data_reg.pulse_ticks, abs_tolerance_reg);
    assign match_b   = near_ref(ref_b, in_data_reg.pulse_ticks, abs_tolerance_reg);
    assign count_inc = bit_count_reg + 6'd1;
    assign shifted   = {shift_word_reg[14:0], match_a};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            bit_count_reg  <= '0;
            shift_word_reg <= '0;
        end else begin
            phase_reg      <= phase_next;
            bit_count_reg  <= bit_count_next;
            shift_word_reg <= shift_word_next;
        end
    end

    always_comb begin
        phase_next         = phase_reg;
        bit_count_next     = bit_count_reg;
        shift_word_next    = shift_word_reg;
        res_valid          = 1'b0;
        res_word.key_code  = shift_word_reg;
        res_word.is_repeat = 1'b0;
        if (advance) begin
            phase_next     = PH_IDLE;
            bit_count_next = '0;
            unique case (phase_reg)
                PH_IDLE: begin
                    if (is_mark && match_a) begin
                        phase_next = PH_HEADER;
                    end
                end
                PH_HEADER: begin
                    if (!is_mark && match_a) begin
                        res_valid          = 1'b1;
                        res_word.is_repeat = 1'b1;
                    end else if (!is_mark && match_b) begin
                        phase_next      = PH_MARK;
                        shift_word_next = '0;
                    end
                end
                PH_MARK: begin
                    if (is_mark && match_a) begin
                        phase_next     = PH_SPACE;
                        bit_count_next = bit_count_reg;
                    end
                end
                PH_SPACE: begin
                    if (!is_mark && (match_a || match_b)) begin
                        shift_word_next = shifted;
                        if (count_inc == ADDR_BITS) begin
                            if (shifted == device_address_reg) begin
                                phase_next      = PH_MARK;
                                bit_count_next  = count_inc;
                                shift_word_next = '0;
                            end
                        end else if (count_inc >= FRAME_BITS) begin
                            res_valid         = 1'b1;
                            res_word.key_code = shifted;
                        end else begin
                            phase_next     = PH_MARK;
                            bit_count_next = count_inc;
                        end
                    end else begin
                        shift_word_next = {shift_word_reg[14:0], 1'b0};
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= advance && res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res_valid) begin
            m_data_reg <= res_word;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_count_only_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_IDLE || phase_reg == PH_HEADER) |-> bit_count_reg == 6'd0)
        else $error("bit count nonzero outside a frame");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        bit_count_reg < FRAME_BITS)
        else $error("bit count ran past the frame length");

    a_result_ends_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && res_valid) |=> phase_reg == PH_IDLE && bit_count_reg == 6'd0)
        else $error("decoder not idle after emitting a word");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && m_valid_reg && !m_ready))
        else $error("input stalled without a blocked output word");

endmodule

>>> test/tb_nec_ir_pulse_decoder.sv
// Testbench for nec_ir_pulse_decoder: directed and random pulse trains checked by a built-in decoder.
module tb_nec_ir_pulse_decoder;
    import nec_ir_pkg::*;

    localparam int STALL_LIMIT   = 3000;
    localparam int SETTLE_CYCLES = 4;

    typedef enum int {
        RDY_ALWAYS,
        RDY_HALF,
        RDY_SPARSE,
        RDY_PERIODIC
    } ready_mode_t;

    typedef enum int {
        SET_DEFAULT,
        SET_ZERO,
        SET_MAX,
        SET_SCALED,
        SET_RANDOM,
        SET_OVERLAP
    } setting_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_wr_en = 1'b0;
    cfg_index_t  cfg_index = CFG_HEADER_MARK;
    logic [15:0] cfg_data  = '0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    in_word_t    s_data    = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    out_word_t   m_data;

    logic [15:0] cfg_shadow [8];
    phase_t      dec_phase;
    logic [5:0]  dec_bits;
    logic [15:0] dec_word;
    out_word_t   pending_keys [$];
    in_word_t    pulse_seq [$];

    int          error_count  = 0;
    int          burst_left   = 0;
    int          hold_req     = 0;
    int          hold_left    = 0;
    ready_mode_t ready_mode   = RDY_ALWAYS;
    int          mode_left    = 0;
    int          rcv_cycle    = 0;
    int          quiet_cycles = 0;

    always #5 aclk = ~aclk;

    nec_ir_pulse_decoder u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    function automatic logic [15:0] reset_value(input cfg_index_t idx);
        case (idx)
            CFG_HEADER_MARK:   return HEADER_MARK_RST;
            CFG_HEADER_SPACE:  return HEADER_SPACE_RST;
            CFG_REPEAT_SPACE:  return REPEAT_SPACE_RST;
            CFG_BIT_MARK:      return BIT_MARK_RST;
            CFG_ONE_SPACE:     return ONE_SPACE_RST;
            CFG_ZERO_SPACE:    return ZERO_SPACE_RST;
            CFG_ABS_TOLERANCE: return ABS_TOLERANCE_RST;
            default:           return DEVICE_ADDRESS_RST;
        endcase
    endfunction

    // Largest deviation from a nominal length that still counts as a match.
    function automatic int unsigned match_slack(input logic [15:0] nominal);
        int unsigned slack;
        slack = nominal / 3;
        if (cfg_shadow[CFG_ABS_TOLERANCE] < slack) begin
            slack = 32'(cfg_shadow[CFG_ABS_TOLERANCE]);
        end
        return slack;
    endfunction

    function automatic logic pulse_fits(input logic [15:0] nominal, input logic [15:0] len);
        int unsigned diff;
        diff = (len >= nominal) ? len - nominal : nominal - len;
        return diff <= match_slack(nominal);
    endfunction

    function automatic void decoder_to_idle();
        dec_phase = PH_IDLE;
        dec_bits  = '0;
    endfunction

    function automatic logic decode_pulse(input in_word_t w, output out_word_t key);
        logic is_mark;
        logic data_bit;
        is_mark = w.pulse_level;
        key     = '0;
        case (dec_phase)
            PH_IDLE: begin
                if (is_mark && pulse_fits(cfg_shadow[CFG_HEADER_MARK], w.pulse_ticks)) begin
                    dec_phase = PH_HEADER;
                end else begin
                    decoder_to_idle();
                end
            end
            PH_HEADER: begin
                if (!is_mark && pulse_fits(cfg_shadow[CFG_REPEAT_SPACE], w.pulse_ticks)) begin
                    key.key_code  = dec_word;
                    key.is_repeat = 1'b1;
                    decoder_to_idle();
                    return 1'b1;
                end
                if (!is_mark && pulse_fits(cfg_shadow[CFG_HEADER_SPACE], w.pulse_ticks)) begin
                    dec_phase = PH_MARK;
                    dec_word  = '0;
                end else begin
                    decoder_to_idle();
                end
            end
            PH_MARK: begin
                if (is_mark && pulse_fits(cfg_shadow[CFG_BIT_MARK], w.pulse_ticks)) begin
                    dec_phase = PH_SPACE;
                end else begin
                    decoder_to_idle();
                end
            end
            PH_SPACE: begin
                if (!is_mark && pulse_fits(cfg_shadow[CFG_ONE_SPACE], w.pulse_ticks)) begin
                    data_bit = 1'b1;
                end else if (!is_mark && pulse_fits(cfg_shadow[CFG_ZERO_SPACE], w.pulse_ticks)) begin
                    data_bit = 1'b0;
                end else begin
                    dec_word = dec_word << 1;
                    decoder_to_idle();
                    return 1'b0;
                end
                dec_bits  = dec_bits + 6'd1;
                dec_word  = {dec_word[14:0], data_bit};
                dec_phase = PH_MARK;
                if (dec_bits == ADDR_BITS) begin
                    if (dec_word != cfg_shadow[CFG_DEVICE_ADDRESS]) begin
                        decoder_to_idle();
                    end else begin
                        dec_word = '0;
                    end
                end else if (dec_bits >= FRAME_BITS) begin
                    key.key_code  = dec_word;
                    key.is_repeat = 1'b0;
                    decoder_to_idle();
                    return 1'b1;
                end
            end
        endcase
        return 1'b0;
    endfunction

    always @(posedge aclk) begin
        out_word_t key;
        out_word_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_keys.size() == 0) begin
                    $display("%0t: unexpected word key_code=%h is_repeat=%b",
                             $time, m_data.key_code, m_data.is_repeat);
                    error_count++;
                end else begin
                    want = pending_keys.pop_front();
                    if (m_data.key_code !== want.key_code) begin
                        $display("%0t: key_code expected %h actual %h",
                                 $time, want.key_code, m_data.key_code);
                        error_count++;
                    end
                    if (m_data.is_repeat !== want.is_repeat) begin
                        $display("%0t: is_repeat expected %b actual %b",
                                 $time, want.is_repeat, m_data.is_repeat);
                        error_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (decode_pulse(s_data, key)) begin
                    pending_keys.push_back(key);
                end
            end
            if (cfg_wr_en) begin
                cfg_shadow[cfg_index] = cfg_data;
            end
        end
    end

    always @(negedge aclk) begin
        rcv_cycle++;
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (mode_left == 0) begin
            ready_mode = ready_mode_t'($urandom_range(0, 3));
            mode_left  = $urandom_range(20, 300);
        end else begin
            mode_left--;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_ready = 1'b0;
        end else begin
            case (ready_mode)
                RDY_ALWAYS: m_ready = 1'b1;
                RDY_HALF:   m_ready = 1'($urandom_range(0, 1));
                RDY_SPARSE: m_ready = ($urandom_range(0, 4) == 0);
                default:    m_ready = (rcv_cycle % 7) < 3;
            endcase
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic pause_sender(input int cycles);
        if (cycles > 0) begin
            @(negedge aclk);
            s_valid = 1'b0;
            repeat (cycles - 1) @(negedge aclk);
        end
    endtask

    task automatic send_pulse(input in_word_t w);
        if (burst_left == 0) begin
            pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 30);
        end
        burst_left--;
        @(negedge aclk);
        s_valid = 1'b1;
        s_data  = w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic send_seq();
        while (pulse_seq.size() != 0) begin
            send_pulse(pulse_seq.pop_front());
        end
    endtask

    task automatic wait_drained();
        pause_sender(1);
        while (pending_keys.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [15:0] value);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    function automatic void add_pulse(input logic level, input logic [15:0] ticks);
        in_word_t w;
        w.pulse_level = level;
        w.pulse_ticks = ticks;
        pulse_seq.push_back(w);
    endfunction

    function automatic logic [15:0] fitting_ticks(input logic [15:0] nominal);
        int unsigned d;
        d = ($urandom_range(0, 3) == 0) ? match_slack(nominal)
                                        : $urandom_range(0, match_slack(nominal));
        if ($urandom_range(0, 1) == 1 && nominal + d <= 65535) begin
            return 16'(nominal + d);
        end
        if (nominal >= d) begin
            return 16'(nominal - d);
        end
        return 16'(nominal + d);
    endfunction

    function automatic logic [15:0] stray_ticks(input logic [15:0] nominal);
        int unsigned off;
        if ($urandom_range(0, 1) == 0) begin
            return 16'($urandom_range(0, 65535));
        end
        off = match_slack(nominal) + 1 + $urandom_range(0, 40);
        if ($urandom_range(0, 1) == 0 && nominal + off <= 65535) begin
            return 16'(nominal + off);
        end
        if (nominal >= off) begin
            return 16'(nominal - off);
        end
        if (nominal + off <= 65535) begin
            return 16'(nominal + off);
        end
        return 16'($urandom_range(0, 65535));
    endfunction

    function automatic void add_repeat();
        add_pulse(1'b1, fitting_ticks(cfg_shadow[CFG_HEADER_MARK]));
        add_pulse(1'b0, fitting_ticks(cfg_shadow[CFG_REPEAT_SPACE]));
    endfunction

    function automatic void add_frame(input logic [15:0] addr, input logic [15:0] cmd);
        logic [31:0] payload;
        payload = {addr, cmd};
        add_pulse(1'b1, fitting_ticks(cfg_shadow[CFG_HEADER_MARK]));
        add_pulse(1'b0, fitting_ticks(cfg_shadow[CFG_HEADER_SPACE]));
        for (int i = 31; i >= 0; i--) begin
            add_pulse(1'b1, fitting_ticks(cfg_shadow[CFG_BIT_MARK]));
            add_pulse(1'b0, fitting_ticks(payload[i] ? cfg_shadow[CFG_ONE_SPACE]
                                                     : cfg_shadow[CFG_ZERO_SPACE]));
        end
    endfunction

    task automatic apply_setting(input setting_t kind);
        logic [15:0] vals [8];
        int unsigned k;
        k = $urandom_range(2, 152);
        for (int i = 0; i < 8; i++) begin
            case (kind)
                SET_DEFAULT: vals[i] = reset_value(cfg_index_t'(i));
                SET_ZERO:    vals[i] = '0;
                SET_MAX:     vals[i] = 16'hFFFF;
                SET_RANDOM:  vals[i] = 16'($urandom_range(0, 65535));
                default:     vals[i] = 16'((reset_value(cfg_index_t'(i)) * k) / 4);
            endcase
        end
        if (kind == SET_SCALED || kind == SET_OVERLAP) begin
            case ($urandom_range(0, 2))
                0:       vals[CFG_ABS_TOLERANCE] = 16'hFFFF;
                1:       vals[CFG_ABS_TOLERANCE] = 16'($urandom_range(0, 65535));
                default: vals[CFG_ABS_TOLERANCE] = 16'($urandom_range(0, k * 25));
            endcase
            vals[CFG_DEVICE_ADDRESS] = 16'($urandom_range(0, 65535));
        end
        // Overlapping references exercise which match wins: every bit reads as a one,
        // and some header spaces also fall into the repeat window.
        if (kind == SET_OVERLAP) begin
            vals[CFG_ZERO_SPACE]     = vals[CFG_ONE_SPACE];
            vals[CFG_REPEAT_SPACE]   = 16'(vals[CFG_HEADER_SPACE] + vals[CFG_HEADER_SPACE] / 4);
            vals[CFG_DEVICE_ADDRESS] = 16'hFFFF;
        end
        for (int i = 0; i < 8; i++) begin
            write_reg(cfg_index_t'(i), vals[i]);
        end
    endtask

    task automatic test_pulse_extremes();
        add_pulse(1'b1, 16'hFFFF);
        add_pulse(1'b0, 16'h0000);
        add_pulse(1'b1, 16'h0000);
        add_pulse(1'b0, 16'hFFFF);
        send_seq();
    endtask

    task automatic test_repeat_header();
        add_pulse(1'b1, HEADER_MARK_RST + 16'd100);
        add_pulse(1'b0, REPEAT_SPACE_RST - 16'd100);
        add_pulse(1'b1, HEADER_MARK_RST + 16'd101);
        add_pulse(1'b0, REPEAT_SPACE_RST);
        send_seq();
    endtask

    task automatic test_held_word();
        add_pulse(1'b1, HEADER_MARK_RST);
        add_pulse(1'b0, HEADER_SPACE_RST);
        repeat (2) begin
            add_pulse(1'b1, BIT_MARK_RST);
            add_pulse(1'b0, ONE_SPACE_RST);
        end
        add_pulse(1'b1, BIT_MARK_RST);
        // A mark where a bit space is due aborts the frame and keeps the partial word, shifted left by one zero bit.
        add_pulse(1'b1, 16'd5000);
        add_pulse(1'b1, HEADER_MARK_RST);
        add_pulse(1'b0, REPEAT_SPACE_RST);
        send_seq();
    endtask

    task automatic test_repeat_precedence();
        wait_drained();
        write_reg(CFG_REPEAT_SPACE, HEADER_SPACE_RST);
        add_pulse(1'b1, HEADER_MARK_RST);
        add_pulse(1'b0, HEADER_SPACE_RST);
        send_seq();
        wait_drained();
        write_reg(CFG_REPEAT_SPACE, REPEAT_SPACE_RST);
    endtask

    task automatic test_output_backpressure();
        hold_req = 150;
        repeat (15) add_repeat();
        send_seq();
        wait_drained();
    endtask

    task automatic test_random_traffic(input setting_t kind, input int items);
        int sent;
        int pick;
        int cut;
        in_word_t w;
        sent = 0;
        wait_drained();
        apply_setting(kind);
        while (sent < items) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                add_frame(cfg_shadow[CFG_DEVICE_ADDRESS], 16'($urandom_range(0, 65535)));
            end else if (pick < 55) begin
                add_frame(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
            end else if (pick < 75) begin
                add_repeat();
            end else if (pick < 90) begin
                add_frame(cfg_shadow[CFG_DEVICE_ADDRESS], 16'($urandom_range(0, 65535)));
                cut = $urandom_range(1, pulse_seq.size() - 1);
                if ($urandom_range(0, 1) == 0) begin
                    w = pulse_seq[cut];
                    if ($urandom_range(0, 1) == 0) begin
                        w.pulse_level = ~w.pulse_level;
                    end else begin
                        w.pulse_ticks = stray_ticks(w.pulse_ticks);
                    end
                    pulse_seq[cut] = w;
                end else begin
                    while (pulse_seq.size() > cut) void'(pulse_seq.pop_back());
                end
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    add_pulse(1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)));
                end
            end
            sent += pulse_seq.size();
            send_seq();
            if ($urandom_range(0, 39) == 0) begin
                wait_drained();
            end
        end
    endtask

    initial begin
        for (int i = 0; i < 8; i++) begin
            cfg_shadow[i] = reset_value(cfg_index_t'(i));
        end
        dec_phase = PH_IDLE;
        dec_bits  = '0;
        dec_word  = '0;
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;

        test_pulse_extremes();
        test_repeat_header();
        test_held_word();
        test_repeat_precedence();
        test_output_backpressure();
        test_random_traffic(SET_DEFAULT, 300);
        test_random_traffic(SET_ZERO, 40);
        test_random_traffic(SET_MAX, 40);
        test_random_traffic(SET_SCALED, 150);
        test_random_traffic(SET_SCALED, 150);
        test_random_traffic(SET_SCALED, 150);
        test_random_traffic(SET_RANDOM, 60);
        test_random_traffic(SET_OVERLAP, 100);

        wait_drained();
        repeat (10) @(posedge aclk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
